@@ rtl/core/fbde_pkg.sv @@
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared constants, operation codes and control/status types of the
// framebuffer draw engine.
// ----------------------------------------------------------------------------
package fbde_pkg;

    // default store geometry
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 13;
    localparam int RAD_W   = 12;
    localparam int COLOR_W = 32;
    localparam int DIM_W   = 8;

    // stream and config port widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;

    // circle arithmetic: radicand, root and signed coordinate widths
    localparam int SQ_W   = 22;
    localparam int ROOT_W = 11;
    localparam int CRD_W  = 15;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT    = 3'd1;
    localparam logic [OP_W-1:0] OP_CIRCLE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_ACK    = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // take the input transaction
        logic decode;       // precompute address, area, circle rows
        logic sweep_step;   // post-reset clearing pass, one word
        logic fill_step;    // clear command, one word
        logic pix_write;    // single pixel write
        logic mem_read;     // single pixel read
        logic set_dirty;
        logic clr_dirty;
        logic row_square;   // dy^2 and row base for current circle row
        logic sqrt_start;
        logic span_init;    // clip span of current row
        logic span_step;    // write one span pixel
        logic row_next;
        logic load_result;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic in_frame;
        logic rad_pos;
        logic sweep_last;
        logic fill_last;
        logic rows_empty;
        logic row_last;
        logic span_empty;
        logic span_last;
        logic sqrt_busy;
    } t_dp_sts;

endpackage

@@ rtl/core/fbde_isqrt.sv @@
// ----------------------------------------------------------------------------
// fbde_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fbde_isqrt
    import fbde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W:0]   w_sum;

    assign w_sum  = {1'b0, r_res} + {1'b0, r_bit};
    assign o_busy = (r_bit != '0);
    assign o_root = r_res[ROOT_W-1:0];

    // bit walks down by powers of four; zero means idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (o_busy) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
        end else if (o_busy) begin
            if ({1'b0, r_v} >= w_sum) begin
                r_v   <= r_v - w_sum[SQ_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

endmodule

@@ rtl/core/fbde_dp.sv @@
// ----------------------------------------------------------------------------
// fbde_dp
// Datapath: config registers, command registers, pixel store, address and
// circle span arithmetic, result register.
// ----------------------------------------------------------------------------
module fbde_dp
    import fbde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_data,
    input  logic [IN_TDATA_W-1:0] i_in_tdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic [COLOR_W-1:0]    o_res_color,
    output logic                  o_res_inb,
    output logic                  o_res_dirty
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = (AW > 2 * DIM_W) ? AW : 2 * DIM_W;
    localparam int FW_RST = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
    localparam int FH_RST = (MAX_HEIGHT < 128) ? MAX_HEIGHT : 128;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int maxv);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (int'(v) > maxv) begin
            return DIM_W'(maxv);
        end
        return v;
    endfunction

    // config
    logic [DIM_W-1:0] r_fw;
    logic [DIM_W-1:0] r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= DIM_W'(FW_RST);
            r_fh <= DIM_W'(FH_RST);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_fw <= sat_dim(i_cfg_data, MAX_WIDTH);
            end else if (i_cfg_index == REG_FRAME_HEIGHT) begin
                r_fh <= sat_dim(i_cfg_data, MAX_HEIGHT);
            end
        end
    end

    // captured command
    logic [OP_W-1:0]         r_op;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic signed [RAD_W-1:0] r_rad;
    logic [COLOR_W-1:0]      r_color;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_tdata[2:0];
            r_px    <= i_in_tdata[15:3];
            r_py    <= i_in_tdata[28:16];
            r_rad   <= i_in_tdata[40:29];
            r_color <= i_in_tdata[72:41];
        end
    end

    logic w_inside;
    logic w_rad_pos;

    assign w_inside  = !r_px[POS_W-1] && (r_px[POS_W-2:0] < (POS_W-1)'(r_fw))
                    && !r_py[POS_W-1] && (r_py[POS_W-2:0] < (POS_W-1)'(r_fh));
    assign w_rad_pos = !r_rad[RAD_W-1] && (r_rad != '0);

    // decode-time arithmetic
    logic [2*DIM_W-1:0]      w_area;
    logic [2*DIM_W-1:0]      w_pix_base;
    logic signed [CRD_W-1:0] w_cx;
    logic signed [CRD_W-1:0] w_cy;
    logic signed [CRD_W-1:0] w_r;
    logic signed [CRD_W-1:0] w_ys;
    logic signed [CRD_W-1:0] w_ye;
    logic signed [CRD_W-1:0] w_fw_m1;
    logic signed [CRD_W-1:0] w_fh_m1;

    assign w_area     = r_fw * r_fh;
    assign w_pix_base = r_py[DIM_W-1:0] * r_fw;
    assign w_cx       = {{(CRD_W-POS_W){r_px[POS_W-1]}}, r_px};
    assign w_cy       = {{(CRD_W-POS_W){r_py[POS_W-1]}}, r_py};
    assign w_r        = {{(CRD_W-RAD_W){r_rad[RAD_W-1]}}, r_rad};
    assign w_ys       = w_cy - w_r;
    assign w_ye       = w_cy + w_r;
    assign w_fw_m1    = $signed({{(CRD_W-DIM_W){1'b0}}, r_fw - DIM_W'(1)});
    assign w_fh_m1    = $signed({{(CRD_W-DIM_W){1'b0}}, r_fh - DIM_W'(1)});

    // circle row state
    logic [AW-1:0]           r_cnt;
    logic [SW-1:0]           r_last_idx;
    logic [AW-1:0]           r_addr;
    logic signed [CRD_W-1:0] r_y;
    logic signed [CRD_W-1:0] r_y1;
    logic signed [CRD_W-1:0] r_x;
    logic signed [CRD_W-1:0] r_x1;
    logic [SQ_W-1:0]         r_r2;
    logic [SQ_W-1:0]         r_sq;
    logic [SW-1:0]           r_row_base;

    logic signed [CRD_W-1:0] w_dy;
    logic signed [CRD_W-1:0] w_dy_abs;
    logic [ROOT_W-1:0]       w_dmag;
    logic [2*DIM_W-1:0]      w_row_base;
    logic [ROOT_W-1:0]       w_half;
    logic signed [CRD_W-1:0] w_half_s;
    logic signed [CRD_W-1:0] w_xs;
    logic signed [CRD_W-1:0] w_xe;
    logic                    w_sqrt_busy;

    assign w_dy       = r_y - w_cy;
    assign w_dy_abs   = w_dy[CRD_W-1] ? -w_dy : w_dy;
    assign w_dmag     = w_dy_abs[ROOT_W-1:0];
    assign w_row_base = r_y[DIM_W-1:0] * r_fw;
    assign w_half_s   = $signed({{(CRD_W-ROOT_W){1'b0}}, w_half});
    assign w_xs       = w_cx - w_half_s;
    assign w_xe       = w_cx + w_half_s;

    fbde_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_r2 - r_sq),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_half)
    );

    // word counter is control state: it drives the post-reset sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.decode) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep_step || i_cmd.fill_step) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_last_idx <= SW'(w_area) - SW'(1);
            r_addr     <= AW'(SW'(w_pix_base) + SW'(r_px[DIM_W-1:0]));
            r_y        <= w_ys[CRD_W-1] ? '0 : w_ys;
            r_y1       <= (w_ye > w_fh_m1) ? w_fh_m1 : w_ye;
            r_r2       <= r_rad[ROOT_W-1:0] * r_rad[ROOT_W-1:0];
        end else if (i_cmd.row_next) begin
            r_y <= r_y + CRD_W'(1);
        end
        if (i_cmd.row_square) begin
            r_sq       <= w_dmag * w_dmag;
            r_row_base <= SW'(w_row_base);
        end
        if (i_cmd.span_init) begin
            r_x  <= w_xs[CRD_W-1] ? '0 : w_xs;
            r_x1 <= (w_xe > w_fw_m1) ? w_fw_m1 : w_xe;
        end else if (i_cmd.span_step) begin
            r_x <= r_x + CRD_W'(1);
        end
    end

    // pixel store, one write and one registered read port
    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_mem_q;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [COLOR_W-1:0] w_wdata;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = r_color;
        if (i_cmd.sweep_step) begin
            w_we    = 1'b1;
            w_wdata = '0;
        end else if (i_cmd.fill_step) begin
            w_we    = 1'b1;
        end else if (i_cmd.pix_write) begin
            w_we    = 1'b1;
            w_waddr = r_addr;
        end else if (i_cmd.span_step) begin
            w_we    = 1'b1;
            w_waddr = AW'(r_row_base + SW'(r_x[DIM_W-1:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.mem_read) begin
            r_mem_q <= r_mem[r_addr];
        end
    end

    // dirty mark
    logic r_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b1;
        end else if (i_cmd.set_dirty) begin
            r_dirty <= 1'b1;
        end else if (i_cmd.clr_dirty) begin
            r_dirty <= 1'b0;
        end
    end

    // result register
    logic w_rd_hit;

    assign w_rd_hit = (r_op == OP_READ) && w_inside;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_res_color <= w_rd_hit ? r_mem_q : '0;
            o_res_inb   <= w_rd_hit;
            o_res_dirty <= r_dirty;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.in_frame   = w_inside;
    assign o_sts.rad_pos    = w_rad_pos;
    assign o_sts.sweep_last = (r_cnt == AW'(DEPTH - 1));
    assign o_sts.fill_last  = (SW'(r_cnt) == r_last_idx);
    assign o_sts.rows_empty = (r_y > r_y1);
    assign o_sts.row_last   = (r_y == r_y1);
    assign o_sts.span_empty = (r_x > r_x1);
    assign o_sts.span_last  = (r_x == r_x1);
    assign o_sts.sqrt_busy  = w_sqrt_busy;

endmodule

@@ rtl/core/fbde_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbde_ctrl
// Command sequencer: reset sweep, dispatch, span loops and result handoff.
// ----------------------------------------------------------------------------
module fbde_ctrl
    import fbde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [13:0] {
        S_SWEEP   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_DECODE  = 14'b00000000000100,
        S_FILL    = 14'b00000000001000,
        S_PUT     = 14'b00000000010000,
        S_READ    = 14'b00000000100000,
        S_C_CHECK = 14'b00000001000000,
        S_C_ROW   = 14'b00000010000000,
        S_C_SQS   = 14'b00000100000000,
        S_C_SQW   = 14'b00001000000000,
        S_C_SPAN  = 14'b00010000000000,
        S_C_FILL  = 14'b00100000000000,
        S_C_NEXT  = 14'b01000000000000,
        S_RESP    = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = S_RESP;
                unique case (i_sts.op)
                    OP_CLEAR: begin
                        o_cmd.set_dirty = 1'b1;
                        n_state         = S_FILL;
                    end
                    OP_PUT: begin
                        if (i_sts.in_frame) begin
                            o_cmd.set_dirty = 1'b1;
                            n_state         = S_PUT;
                        end
                    end
                    OP_CIRCLE: begin
                        if (i_sts.rad_pos) begin
                            o_cmd.set_dirty = 1'b1;
                            n_state         = S_C_CHECK;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.in_frame) n_state = S_READ;
                    end
                    OP_ACK: begin
                        o_cmd.clr_dirty = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) n_state = S_RESP;
            end
            S_PUT: begin
                o_cmd.pix_write = 1'b1;
                n_state         = S_RESP;
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_RESP;
            end
            S_C_CHECK: begin
                n_state = i_sts.rows_empty ? S_RESP : S_C_ROW;
            end
            S_C_ROW: begin
                o_cmd.row_square = 1'b1;
                n_state          = S_C_SQS;
            end
            S_C_SQS: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_C_SQW;
            end
            S_C_SQW: begin
                if (!i_sts.sqrt_busy) begin
                    o_cmd.span_init = 1'b1;
                    n_state         = S_C_SPAN;
                end
            end
            S_C_SPAN: begin
                n_state = i_sts.span_empty ? S_C_NEXT : S_C_FILL;
            end
            S_C_FILL: begin
                o_cmd.span_step = 1'b1;
                if (i_sts.span_last) n_state = S_C_NEXT;
            end
            S_C_NEXT: begin
                if (i_sts.row_last) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.row_next = 1'b1;
                    n_state        = S_C_ROW;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.load_result) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/framebuffer_draw_engine_core.sv @@
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_core - RGBA drawing engine (clear, pixel, disc, read)
// Pixel writes: one per cycle, bounded by the store port.
// Throughput: one command at a time, next one taken once its result is loaded.
// Reset: sweeps zeros through all MAX_WIDTH*MAX_HEIGHT words, one per cycle,
// no input taken meanwhile.
// ----------------------------------------------------------------------------
//
// One command is worked at a time. A finished result sits in the output
// register, so the next command is accepted while that result waits.
// The disc loop runs per row: square dy, take the floor root in the single
// root unit, clip the span, then write the span pixels.
//
module framebuffer_draw_engine_core
    import fbde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_data,
    // command stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: operation[2:0], x_pos[15:3], y_pos[28:16], radius[40:29],
    //        color[72:41], zero[79:73]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: read_color[31:0], read_in_bounds[32], dirty_mark[33], zero[39:34]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;
    logic [COLOR_W-1:0] w_res_color;
    logic               w_res_inb;
    logic               w_res_dirty;

    // config writes must be issued only while idle; not enforced here, always take them
    assign o_cfg_ready = 1'b1;

    fbde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    fbde_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_tdata  (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_color (w_res_color),
        .o_res_inb   (w_res_inb),
        .o_res_dirty (w_res_dirty)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-COLOR_W-2){1'b0}},
                             w_res_dirty, w_res_inb, w_res_color};

`ifndef ASSERT_OFF
    // a loaded result shows up as a valid transaction on the next cycle
    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_result |=> o_m_axis_tvalid)
        else $error("result loaded but output not valid");

    // an out-of-bounds or non-read result never carries pixel data
    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[32]) |-> (o_m_axis_tdata[31:0] == '0))
        else $error("read_color nonzero without in-bounds read");

    // no new command while the root unit is still iterating
    a_capture_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |-> !w_sts.sqrt_busy)
        else $error("command captured while square root busy");
`endif

endmodule

@@ tb/sv/fbde_readback_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbde_readback_checker
// Watches the register, command and result channels of the draw engine. It
// keeps its own pixel store, dirty mark and frame size, works out the result
// of each command transaction, and compares the results in order.
// ----------------------------------------------------------------------------
module fbde_readback_checker
    import fbde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_data,
    input  logic                   i_cmd_valid,
    input  logic                   i_cmd_ready,
    input  logic [IN_TDATA_W-1:0]  i_cmd_data,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [OUT_TDATA_W-1:0] i_res_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int MAX_REPORTS = 10;

    // same bit order as the result tdata, color in the low bits
    typedef struct packed {
        logic               dirty;
        logic               in_bounds;
        logic [COLOR_W-1:0] color;
    } t_readback;

    logic [COLOR_W-1:0] shadow_px [STORE_WORDS];
    logic               shadow_dirty = 1'b1;
    int                 fb_width     = MAX_WIDTH;
    int                 fb_height    = MAX_HEIGHT;
    t_readback          due_readbacks [$];
    int                 fails   = 0;
    int                 checked = 0;

    // out-of-range writes: zero becomes one, too large saturates
    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    // largest root with root*root <= v, built one bit at a time
    function automatic int floor_root(input int v);
        int root;
        int cand;
        int b;
        root = 0;
        for (b = ROOT_W; b >= 0; b--) begin
            cand = root | (1 << b);
            if (cand * cand <= v) root = cand;
        end
        return root;
    endfunction

    // runs one command on the shadow store, returns what the engine must send
    function automatic t_readback draw_command(input logic [IN_TDATA_W-1:0] word);
        logic [OP_W-1:0]    op;
        logic [COLOR_W-1:0] paint;
        int                 cx, cy, rad, rad_sq;
        int                 row, col, ylo, yhi, xlo, xhi, half, dy, i;
        logic               on_screen;
        t_readback          res;
        op        = word[OP_W-1:0];
        cx        = int'($signed(word[OP_W +: POS_W]));
        cy        = int'($signed(word[OP_W+POS_W +: POS_W]));
        rad       = int'($signed(word[OP_W+2*POS_W +: RAD_W]));
        paint     = word[OP_W+2*POS_W+RAD_W +: COLOR_W];
        on_screen = cx >= 0 && cx < fb_width && cy >= 0 && cy < fb_height;
        res       = '0;
        case (op)
            OP_CLEAR: begin
                for (i = 0; i < fb_width * fb_height; i++) shadow_px[i] = paint;
                shadow_dirty = 1'b1;
            end
            OP_PUT: begin
                if (on_screen) begin
                    shadow_px[cy * fb_width + cx] = paint;
                    shadow_dirty = 1'b1;
                end
            end
            OP_CIRCLE: begin
                if (rad > 0) begin
                    rad_sq = rad * rad;
                    ylo = (cy - rad < 0) ? 0 : cy - rad;
                    yhi = (cy + rad >= fb_height) ? fb_height - 1 : cy + rad;
                    for (row = ylo; row <= yhi; row++) begin
                        dy   = row - cy;
                        half = floor_root(rad_sq - dy * dy);
                        xlo  = (cx - half < 0) ? 0 : cx - half;
                        xhi  = (cx + half >= fb_width) ? fb_width - 1 : cx + half;
                        for (col = xlo; col <= xhi; col++)
                            shadow_px[row * fb_width + col] = paint;
                    end
                    // set even when every row clipped away
                    shadow_dirty = 1'b1;
                end
            end
            OP_READ: begin
                if (on_screen) begin
                    res.color     = shadow_px[cy * fb_width + cx];
                    res.in_bounds = 1'b1;
                end
            end
            OP_ACK: begin
                shadow_dirty = 1'b0;
            end
            default: ;
        endcase
        res.dirty = shadow_dirty;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [COLOR_W-1:0] want,
                                input logic [COLOR_W-1:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: result %0d mismatch on %s: expected %h, got %h",
                         $time, checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_readback want;
        t_readback got;
        if (!i_rst_n) begin
            foreach (shadow_px[i]) shadow_px[i] = '0;
            shadow_dirty = 1'b1;
            fb_width     = MAX_WIDTH;
            fb_height    = MAX_HEIGHT;
            due_readbacks.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = t_readback'(i_res_data[$bits(t_readback)-1:0]);
                if (due_readbacks.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: result transaction with nothing due: %h",
                                 $time, i_res_data);
                end else begin
                    want = due_readbacks.pop_front();
                    checked++;
                    report_field("read_color", want.color, got.color);
                    report_field("read_in_bounds", COLOR_W'(want.in_bounds),
                                 COLOR_W'(got.in_bounds));
                    report_field("dirty_mark", COLOR_W'(want.dirty), COLOR_W'(got.dirty));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  fb_width  = clamp_dim(i_cfg_data, MAX_WIDTH);
                    REG_FRAME_HEIGHT: fb_height = clamp_dim(i_cfg_data, MAX_HEIGHT);
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready)
                due_readbacks.push_back(draw_command(i_cmd_data));
        end
        o_fail_count <= fails;
        o_pending    <= due_readbacks.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for framebuffer_draw_engine_core: a directed set of
// edge cases at full frame size, then random commands across a series of
// frame sizes, with random gaps and stalls on both streams and one long
// result stall. Checking lives in fbde_readback_checker.
// ----------------------------------------------------------------------------
module testbench;
    import fbde_pkg::*;

    localparam int LIMIT_CYCLES = 16_000_000; // far above the slowest legal run
    localparam int DRAIN_CYCLES = 64;         // quiet time after the last result
    localparam int HOLD_CYCLES  = 600;        // long result stall
    localparam int IDLE_PCT     = 34;

    // codes the engine must ignore
    localparam logic [OP_W-1:0]      OP_SPARE_FIRST  = 3'd5;
    localparam logic [OP_W-1:0]      OP_SPARE_LAST   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 2'd3;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data  = '0;
    logic                   cmd_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  cmd_data  = '0;
    logic                   res_ready = 1'b0;
    wire                    cfg_ready;
    wire                    cmd_ready;
    wire                    res_valid;
    wire [OUT_TDATA_W-1:0]  res_data;

    int fail_count;
    int pending;
    int checked;

    bit idling       = 1'b1;  // random gaps on both streams
    int hold_request = 0;     // bumped to ask the receiver for a long stall
    int hold_served  = 0;
    int cycles       = 0;
    int items_sent   = 0;
    int reg_writes   = 0;
    int settings     = 0;
    // frame size in effect, only used to aim coordinates and radii at the screen
    int frame_w      = DEF_MAX_WIDTH;
    int frame_h      = DEF_MAX_HEIGHT;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    framebuffer_draw_engine_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    fbde_readback_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .i_cmd_data   (cmd_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles with %0d results still due", cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side. Random back-pressure, or a long hold when asked; the hold
    // is counted here so the sender keeps pushing commands meanwhile.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_request) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = hold_request;
            end else begin
                res_ready <= !idling || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // One command transaction. tvalid stays high on return so back-to-back
    // commands follow without a gap; whoever stops sending lowers it.
    task automatic issue(input logic [OP_W-1:0] op, input int x, input int y,
                         input int r, input logic [COLOR_W-1:0] paint);
        logic [POS_W-1:0] xf;
        logic [POS_W-1:0] yf;
        logic [RAD_W-1:0] rf;
        xf = POS_W'(x);
        yf = POS_W'(y);
        rf = RAD_W'(r);
        if (idling && $urandom_range(99) < IDLE_PCT) begin
            cmd_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        cmd_data  <= IN_TDATA_W'({paint, rf, yf, xf, op});
        cmd_valid <= 1'b1;
        do @(posedge i_clk); while (!cmd_ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        reg_writes++;
    endtask

    // New frame size, only once every result of the last phase is back.
    // Raw values go to the engine; out-of-range ones test its clamping.
    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input bit poke_spare);
        cmd_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        if (poke_spare)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                      DIM_W'($urandom));
        cfg_valid <= 1'b0;
        frame_w = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w));
        frame_h = (h == 0) ? 1 : ((h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(h));
        settings++;
    endtask

    // Mostly on-screen coordinates and modest radii so reads land on pixels
    // that earlier commands painted; the rest is full-range noise.
    task automatic random_command();
        int              pick;
        int              x, y, r, span;
        logic [OP_W-1:0] op;
        pick = $urandom_range(99);
        if (pick < 4)       op = OP_CLEAR;
        else if (pick < 30) op = OP_PUT;
        else if (pick < 50) op = OP_CIRCLE;
        else if (pick < 82) op = OP_READ;
        else if (pick < 92) op = OP_ACK;
        else                op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        if ($urandom_range(99) < 85) begin
            x = int'($urandom_range(frame_w + 1)) - 1;
            y = int'($urandom_range(frame_h + 1)) - 1;
        end else begin
            x = $urandom;
            y = $urandom;
        end
        span = ((frame_w > frame_h) ? frame_w : frame_h) / 2 + 3;
        pick = $urandom_range(99);
        if (pick < 70)      r = $urandom_range(span, 1);
        else if (pick < 80) r = int'($urandom_range(1)) - 1;   // zero or minus one
        else if (pick < 92) r = $urandom;                       // any 12-bit value
        else                r = $urandom_range(2047, 1000);
        issue(op, x, y, r, $urandom);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset frame size 128 x 128 ---
        issue(OP_READ, 0, 0, 0, '0);                      // store starts zero, mark set
        issue(OP_ACK, 0, 0, 0, '0);
        issue(OP_PUT, -1, 0, 0, 32'hFFFF_FFFF);           // off the left edge
        issue(OP_PUT, 128, 127, 0, 32'hFFFF_FFFF);        // one past the right edge
        issue(OP_PUT, 0, 128, 0, 32'hFFFF_FFFF);          // one past the bottom
        issue(OP_READ, 4095, -4096, 0, '0);               // coordinate extremes
        issue(OP_READ, -4096, 4095, 0, '0);
        issue(OP_CIRCLE, 10, 10, 0, 32'hFFFF_FFFF);       // zero radius: no mark
        issue(OP_CIRCLE, 10, 10, -1, 32'hFFFF_FFFF);
        issue(OP_CIRCLE, 10, 10, -2048, 32'hFFFF_FFFF);
        issue(OP_CIRCLE, -4096, -4096, 5, 32'hFFFF_FFFF); // off screen, still marks
        issue(OP_ACK, 0, 0, 0, '0);
        issue(OP_PUT, 127, 127, 0, 32'hFFFF_FFFF);
        issue(OP_READ, 127, 127, 0, '0);
        issue(OP_CIRCLE, 0, 0, 1, 32'h8000_0001);         // clipped at the corner
        issue(OP_READ, 1, 0, 0, '0);
        issue(OP_CIRCLE, 4095, 4095, 2047, 32'h1234_5678);// every row below screen
        issue(OP_CIRCLE, 64, 64, 2047, 32'hDEAD_BEEF);    // covers the whole frame
        issue(OP_READ, 127, 0, 0, '0);
        issue(OP_CLEAR, 0, 0, 0, 32'h5A5A_A5A5);
        issue(OP_READ, 64, 127, 0, '0);
        issue(OP_SPARE_FIRST, 1, 1, 1, 32'hFFFF_FFFF);
        issue(OP_SPARE_LAST, 4095, 4095, 2047, 32'hFFFF_FFFF);
        issue(OP_READ, 1, 1, 0, '0);

        // --- random, one phase per frame size ---
        set_frame(8'd0, 8'd0, 1'b1);       // both clamp up to 1 x 1
        repeat (100) random_command();
        set_frame(8'd0, 8'd255, 1'b0);     // 1 x 128, height saturates
        repeat (150) random_command();
        set_frame(8'd255, 8'd1, 1'b1);     // 128 x 1, stride changes under old pixels
        repeat (150) random_command();
        idling = 1'b0;                     // full-rate stretch
        set_frame(8'd8, 8'd8, 1'b0);
        repeat (300) random_command();
        idling = 1'b1;
        set_frame(8'd13, 8'd7, 1'b0);
        repeat (300) random_command();
        set_frame(8'd32, 8'd24, 1'b1);
        repeat (300) random_command();
        set_frame(8'd129, 8'd128, 1'b0);   // back to full size
        repeat (60) random_command();
        set_frame(8'd20, 8'd31, 1'b0);
        repeat (100) random_command();
        // long result stall while commands keep coming: the engine must fill
        // its output register and then hold off the command stream
        idling = 1'b0;
        hold_request++;
        repeat (40) random_command();
        idling = 1'b1;
        repeat (160) random_command();
        set_frame(8'd5, 8'd3, 1'b1);
        repeat (240) random_command();

        cmd_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d commands over %0d frame sizes and %0d register writes",
                 items_sent, settings, reg_writes);
        $display("%0d results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
